[rtl/aesbe_pkg.sv]
// ----------------------------------------------------------------------------
// aesbe_pkg: shared types and constants for the AES-128 block encryptor
// Payload structs, command codes, cell controls and the GF(2^8) multiply.
// ----------------------------------------------------------------------------
package aesbe_pkg;

    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_SBOX = 2'd1;
    localparam logic [1:0] CMD_ENC  = 2'd2;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  entry_index;
        logic [31:0] load_word;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } in_item_t;

    typedef struct packed {
        logic [63:0] cipher_hi;
        logic [63:0] cipher_lo;
    } out_item_t;

    // per-cycle controls shared by every byte cell
    typedef struct packed {
        logic load;
        logic step_byte;
        logic step_col;
        logic permute;
    } cell_ctl_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
            begin
                acc = acc ^ x;
            end
            x = x[7] ? ((x << 1) ^ GF_POLY) : (x << 1);
        end
        return acc;
    endfunction

endpackage

[rtl/aesbe_cell.sv]
// ----------------------------------------------------------------------------
// aesbe_cell: one state byte of the cell chain
// Holds a byte; loads plaintext, takes its byte or column shift input, or takes a permuted byte.
// ----------------------------------------------------------------------------
module aesbe_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  aesbe_pkg::cell_ctl_t  ctl,
    input  logic [7:0]            load_d,
    input  logic [7:0]            byte_d,
    input  logic [7:0]            col_d,
    input  logic [7:0]            perm_d,
    output logic [7:0]            q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load)
        begin
            byte_next = load_d;
        end
        else if (ctl.step_byte)
        begin
            byte_next = byte_d;
        end
        else if (ctl.step_col)
        begin
            byte_next = col_d;
        end
        else if (ctl.permute)
        begin
            byte_next = perm_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

[rtl/aesbe_mixcol.sv]
// ----------------------------------------------------------------------------
// aesbe_mixcol: column mix and round key add
// Mixes one column with the coefficient word (or passes it) and adds a key word.
// ----------------------------------------------------------------------------
module aesbe_mixcol
(
    input  logic [3:0][7:0] col_in,
    input  logic [31:0]     coef,
    input  logic            mix_en,
    input  logic [31:0]     key_word,
    output logic [3:0][7:0] col_out
);

    logic [3:0][7:0] coef_b;
    logic [3:0][7:0] mixed;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            coef_b[k] = coef[31 - 8 * k -: 8];
        end
        for (int j = 0; j < 4; j++)
        begin
            mixed[j] = 8'h00;
            for (int k = 0; k < 4; k++)
            begin
                mixed[j] = mixed[j] ^ aesbe_pkg::gf_mul(col_in[k], coef_b[(k + 7 - j) % 4]);
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            col_out[j] = (mix_en ? mixed[j] : col_in[j]) ^ key_word[31 - 8 * j -: 8];
        end
    end

endmodule

[rtl/aesbe_mem.sv]
// ----------------------------------------------------------------------------
// aesbe_mem: single-write, single-read memory with registered read data
// Serves as the S-box table and as the round key store.
// ----------------------------------------------------------------------------
module aesbe_mem
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    parameter int AW    = 8
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/aes128_block_encrypt.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt: iterative AES-128 encryptor on a chain of byte cells
// Loadable S-box and round keys, configurable MixColumns coefficients.
// ----------------------------------------------------------------------------
// The state lives in sixteen byte cells in column-major order. Load items
// (round key word, S-box entry) give no transfer on the output. An encrypt
// item runs an initial key pass, then a SubBytes pass and a key pass for
// each round, and a finishing step that moves the state into the output
// register once that register is free. Each SubBytes pass rotates all
// sixteen bytes through the single read port of the S-box memory plus its
// read register, and each key pass rotates the four columns through the
// mix unit and the key store read port; its first step applies ShiftRows in
// every pass but the initial one. One item is worked at a time; a new item
// is accepted once the previous result has moved into the output register.
// Round keys and S-box entries must be written before an encrypt uses them.
// ----------------------------------------------------------------------------
module aes128_block_encrypt
#(
    parameter int ROUNDS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  aesbe_pkg::in_item_t   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output aesbe_pkg::out_item_t  out_data,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data
);

    localparam int KEY_DEPTH = 4 * (ROUNDS + 1);
    localparam int KEY_AW    = $clog2(KEY_DEPTH);
    localparam int RW        = $clog2(ROUNDS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_SUB  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [4:0] KEY_LAST = 5'd4;
    localparam logic [4:0] SUB_LAST = 5'd16;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [4:0]    step_reg;
    logic [4:0]    step_next;
    logic [RW-1:0] round_reg;
    logic [RW-1:0] round_next;
    logic [31:0]   coef_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    aesbe_pkg::out_item_t out_data_reg;

    logic                   in_xfer;
    logic                   load_block;
    logic                   out_load;
    aesbe_pkg::cell_ctl_t   ctl;
    logic [7:0]             cell_q [16];
    logic [7:0]             sbox_rdata;
    logic [31:0]            key_rdata;
    logic [KEY_AW-1:0]      key_raddr;
    logic                   key_rd_en;
    logic                   key_wr_en;
    logic                   sbox_wr_en;
    logic                   mix_en;
    logic [3:0][7:0]        col_head;
    logic [3:0][7:0]        col_new;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    assign key_wr_en  = in_xfer && (in_data.cmd == aesbe_pkg::CMD_KEY)
                        && (in_data.entry_index < 8'(KEY_DEPTH));
    assign sbox_wr_en = in_xfer && (in_data.cmd == aesbe_pkg::CMD_SBOX);
    assign load_block = in_xfer && (in_data.cmd == aesbe_pkg::CMD_ENC);

    // key word for column k of the current round; fetched in the step before its use
    assign key_raddr = KEY_AW'({round_reg, 2'b00}) + KEY_AW'(step_reg[1:0]);
    assign key_rd_en = (state_reg == ST_KEY) && (step_reg < KEY_LAST);

    // no MixColumns on the initial key add and on the last round
    assign mix_en = (round_reg != '0) && (round_reg != RW'(ROUNDS));

    always_comb
    begin
        ctl.load      = load_block;
        ctl.step_byte = (state_reg == ST_SUB);
        ctl.step_col  = (state_reg == ST_KEY) && (step_reg != 5'd0);
        ctl.permute   = (state_reg == ST_KEY) && (step_reg == 5'd0) && (round_reg != '0);
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            col_head[j] = cell_q[j];
        end
    end

    aesbe_mixcol u_mixcol
    (
        .col_in   (col_head),
        .coef     (coef_reg),
        .mix_en   (mix_en),
        .key_word (key_rdata),
        .col_out  (col_new)
    );

    aesbe_mem
    #(
        .DEPTH (256),
        .WIDTH (8),
        .AW    (8)
    )
    u_sbox
    (
        .clk     (clk),
        .wr_en   (sbox_wr_en),
        .wr_addr (in_data.entry_index),
        .wr_data (in_data.load_word[7:0]),
        .rd_en   (state_reg == ST_SUB),
        .rd_addr (cell_q[0]),
        .rd_data (sbox_rdata)
    );

    aesbe_mem
    #(
        .DEPTH (KEY_DEPTH),
        .WIDTH (32),
        .AW    (KEY_AW)
    )
    u_keys
    (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (in_data.entry_index[KEY_AW-1:0]),
        .wr_data (in_data.load_word),
        .rd_en   (key_rd_en),
        .rd_addr (key_raddr),
        .rd_data (key_rdata)
    );

    // byte chain: shift toward cell 0; the tail takes the S-box read data,
    // so one full turn of the 17-register loop carries every byte once through the S-box and home again
    for (genvar i = 0; i < 16; i++)
    begin : g_cell
        localparam int R = i % 4;
        localparam int C = i / 4;
        localparam int P = R + 4 * ((C + R) % 4);
        logic [7:0] load_d;
        logic [7:0] byte_d;
        logic [7:0] col_d;

        if (i < 8)
        begin : g_hi
            assign load_d = in_data.block_hi[63 - 8 * i -: 8];
        end
        else
        begin : g_lo
            assign load_d = in_data.block_lo[63 - 8 * (i - 8) -: 8];
        end

        if (i < 15)
        begin : g_bnb
            assign byte_d = cell_q[i + 1];
        end
        else
        begin : g_btail
            assign byte_d = sbox_rdata;
        end

        if (i < 12)
        begin : g_cnb
            assign col_d = cell_q[i + 4];
        end
        else
        begin : g_ctail
            assign col_d = col_new[i - 12];
        end

        aesbe_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .load_d (load_d),
            .byte_d (byte_d),
            .col_d  (col_d),
            .perm_d (cell_q[P]),
            .q      (cell_q[i])
        );
    end

    // sequencer: initial key pass, then SubBytes and key pass per round, then the output load
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        round_next = round_reg;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_block)
                begin
                    state_next = ST_KEY;
                    step_next  = 5'd0;
                    round_next = '0;
                end
            end
            ST_KEY:
            begin
                if (step_reg == KEY_LAST)
                begin
                    step_next = 5'd0;
                    if (round_reg == RW'(ROUNDS))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        round_next = round_reg + RW'(1);
                        state_next = ST_SUB;
                    end
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_SUB:
            begin
                if (step_reg == SUB_LAST)
                begin
                    step_next  = 5'd0;
                    state_next = ST_KEY;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 5'd0;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
            coef_reg      <= 32'h03010102;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                coef_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.cipher_hi <= {cell_q[0], cell_q[1], cell_q[2], cell_q[3],
                                       cell_q[4], cell_q[5], cell_q[6], cell_q[7]};
            out_data_reg.cipher_lo <= {cell_q[8], cell_q[9], cell_q[10], cell_q[11],
                                       cell_q[12], cell_q[13], cell_q[14], cell_q[15]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without a finished encryption");

    a_enc_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load_block |=> (state_reg == ST_KEY) && (step_reg == 5'd0) && (round_reg == '0))
        else $error("encrypt transfer did not start the initial key pass");

    a_sub_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUB) |-> (step_reg <= SUB_LAST) && (round_reg != '0))
        else $error("SubBytes pass out of range");

    a_key_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY) |-> (step_reg <= KEY_LAST) && (round_reg <= RW'(ROUNDS)))
        else $error("key pass out of range");

    a_done_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_DONE) |-> $past(round_reg) == RW'(ROUNDS))
        else $error("finished before the last round");
`endif

endmodule

[tb/aes128_block_encrypt_tb.sv]
// ----------------------------------------------------------------------------
// aes128_block_encrypt_tb: self-checking bench for the AES-128 block encryptor
// Fills the key and S-box stores, then runs directed and random transfers
// under several MixColumns coefficient words. A local predictor checks every
// ciphertext. Random idling and stalls are applied on both sides.
// ----------------------------------------------------------------------------
module aes128_block_encrypt_tb;

    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         KEY_WORDS  = 44;
    localparam int         DRAIN_WAIT = 300;
    localparam int         STALL_LIMIT = 20000; // cycles without any transfer

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    aesbe_pkg::in_item_t  in_data;
    logic                 out_valid;
    logic                 out_stall;
    aesbe_pkg::out_item_t out_data;
    logic                 cfg_wr_en;
    logic [31:0]          cfg_wr_data;

    // predictor state
    logic [31:0] key_mem [KEY_WORDS];
    logic [7:0]  sbox_mem [256];
    logic [31:0] mix_word;

    aesbe_pkg::in_item_t  pending_items[$];
    aesbe_pkg::out_item_t cipher_queue[$];

    // control flags set by the stimulus process, and the receiver hold counter
    logic        calm;
    logic        tx_pause;
    logic        rx_hold_req;
    int          rx_hold_left;

    int          errors;
    int          cipher_count;
    int          load_count;
    int          idle_cycles;

    aes128_block_encrypt dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // GF(2^8) product reduced by the AES polynomial
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int n = 0; n < 8; n++)
        begin
            if (b[n])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return acc;
    endfunction

    // run the ten rounds on the current stores and coefficient word
    function automatic aesbe_pkg::out_item_t cipher_of(input logic [63:0] hi,
                                                       input logic [63:0] lo);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] coef [4];
        logic [7:0] v;
        aesbe_pkg::out_item_t res;
        for (int i = 0; i < 8; i++)
        begin
            st[i]     = hi[63 - 8*i -: 8];
            st[8 + i] = lo[63 - 8*i -: 8];
        end
        for (int k = 0; k < 4; k++)
            coef[k] = mix_word[31 - 8*k -: 8];
        for (int rnd = 0; rnd <= 10; rnd++)
        begin
            if (rnd > 0)
            begin
                for (int i = 0; i < 16; i++)
                    tmp[i] = sbox_mem[st[i]];
                // shift row r left by r columns
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        st[r + 4*c] = tmp[r + 4*((c + r) % 4)];
                if (rnd < 10)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int j = 0; j < 4; j++)
                        begin
                            v = 8'h00;
                            for (int k = 0; k < 4; k++)
                                v ^= field_mul(st[k + 4*c], coef[(k - j + 7) % 4]);
                            tmp[j] = v;
                        end
                        for (int j = 0; j < 4; j++)
                            st[j + 4*c] = tmp[j];
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    st[r + 4*c] ^= key_mem[4*rnd + c][31 - 8*r -: 8];
        end
        for (int i = 0; i < 8; i++)
        begin
            res.cipher_hi[63 - 8*i -: 8] = st[i];
            res.cipher_lo[63 - 8*i -: 8] = st[8 + i];
        end
        return res;
    endfunction

    // update the stores or queue the ciphertext for one accepted transfer
    task automatic absorb_item(input aesbe_pkg::in_item_t it);
        case (it.cmd)
            aesbe_pkg::CMD_KEY:
            begin
                if (it.entry_index < KEY_WORDS)
                    key_mem[it.entry_index] = it.load_word;
                load_count++;
            end
            aesbe_pkg::CMD_SBOX:
            begin
                sbox_mem[it.entry_index] = it.load_word[7:0];
                load_count++;
            end
            aesbe_pkg::CMD_ENC:
                cipher_queue.push_back(cipher_of(it.block_hi, it.block_lo));
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic aesbe_pkg::in_item_t make_item(input logic [1:0] cmd,
                                                      input logic [7:0] idx,
                                                      input logic [31:0] word,
                                                      input logic [63:0] hi,
                                                      input logic [63:0] lo);
        aesbe_pkg::in_item_t it;
        it.cmd         = cmd;
        it.entry_index = idx;
        it.load_word   = word;
        it.block_hi    = hi;
        it.block_lo    = lo;
        return it;
    endfunction

    // random item: mostly encrypts, with loads, stray key indexes and unused codes
    function automatic aesbe_pkg::in_item_t random_item();
        aesbe_pkg::in_item_t it;
        int                  pick;
        it   = make_item(aesbe_pkg::CMD_ENC, 8'($urandom), $urandom, {$urandom, $urandom},
                         {$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 18)
        begin
            it.cmd = aesbe_pkg::CMD_KEY;
            if (pick < 14)
                it.entry_index = 8'($urandom_range(KEY_WORDS - 1));
        end
        else if (pick < 36)
            it.cmd = aesbe_pkg::CMD_SBOX;
        else if (pick < 41)
            it.cmd = CMD_NONE;
        return it;
    endfunction

    // Driver: advance to the next item only when the current one is not stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                absorb_item(in_data);
            if (pending_items.size() > 0 && !tx_pause
                && (calm || $urandom_range(99) >= 26))
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transfer, and drive the receiver stall.
    always @(posedge clk or negedge rst_n)
    begin
        aesbe_pkg::out_item_t want;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cipher_queue.size() == 0)
                begin
                    report_mismatch("unexpected cipher_hi", out_data.cipher_hi, '0);
                end
                else
                begin
                    want = cipher_queue.pop_front();
                    if (out_data.cipher_hi !== want.cipher_hi)
                        report_mismatch("cipher_hi", out_data.cipher_hi, want.cipher_hi);
                    if (out_data.cipher_lo !== want.cipher_lo)
                        report_mismatch("cipher_lo", out_data.cipher_lo, want.cipher_lo);
                    cipher_count++;
                end
            end
            // hold off for a long stretch on request, else stall at random unless calm
            if (rx_hold_req && rx_hold_left == 0)
            begin
                rx_hold_left <= 900;
                out_stall    <= 1'b1;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left <= rx_hold_left - 1;
                out_stall    <= (rx_hold_left > 1);
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 26);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d ciphertexts outstanding",
                     cipher_queue.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // wait until the block is idle, then let the last encrypt settle
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || cipher_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_coefficients(input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mix_word = value;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    initial
    begin
        logic [31:0] settings [5];
        mix_word     = 32'h03010102;
        calm         = 1'b0;
        tx_pause     = 1'b0;
        rx_hold_req  = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every key word and S-box entry so that no encrypt reads an unwritten one.
        for (int i = 0; i < KEY_WORDS; i++)
            pending_items.push_back(make_item(aesbe_pkg::CMD_KEY, 8'(i), $urandom,
                                              {2{$urandom}}, {2{$urandom}}));
        for (int i = 0; i < 256; i++)
            pending_items.push_back(make_item(aesbe_pkg::CMD_SBOX, 8'(i), $urandom,
                                              {2{$urandom}}, {2{$urandom}}));

        // Directed: extreme blocks, ignored key indexes, the unused code, full S-box value.
        pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'h00, 32'h0, 64'h0, 64'h0));
        pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'hff, '1, '1, '1));
        pending_items.push_back(make_item(aesbe_pkg::CMD_KEY, 8'd44, 32'hffffffff, '1, '1));
        pending_items.push_back(make_item(aesbe_pkg::CMD_KEY, 8'hff, 32'h12345678, '0, '0));
        pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'h00, 32'h0, 64'h0, 64'h0));
        pending_items.push_back(make_item(CMD_NONE, 8'hff, '1, '1, '1));
        pending_items.push_back(make_item(CMD_NONE, 8'h00, '0, '0, '0));
        pending_items.push_back(make_item(aesbe_pkg::CMD_SBOX, 8'hff, 32'hffffffff, '0, '0));
        pending_items.push_back(make_item(aesbe_pkg::CMD_SBOX, 8'h00, 32'h00000000, '1, '1));
        pending_items.push_back(make_item(aesbe_pkg::CMD_KEY, 8'd0, 32'hffffffff, '0, '0));
        pending_items.push_back(make_item(aesbe_pkg::CMD_KEY, 8'd43, 32'h00000000, '1, '1));
        pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'h00, 32'h0,
                                          64'h0123456789abcdef, 64'hfedcba9876543210));
        pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'h2a, 32'h5, '1, 64'h0));
        drain();

        // Step through coefficient words, the extremes and the reset value among them.
        settings[0] = 32'h03010102;
        settings[1] = 32'h00000000;
        settings[2] = 32'hffffffff;
        settings[3] = $urandom;
        settings[4] = $urandom;
        for (int p = 0; p < 5; p++)
        begin
            write_coefficients(settings[p]);
            pending_items.push_back(make_item(aesbe_pkg::CMD_ENC, 8'h00, 32'h0, '1, '0));
            calm = (p == 1);
            if (p == 2)
            begin
                // hold the receiver off so the block fills and stalls its input
                rx_hold_req = 1'b1;
                queue_random(30);
                repeat (5) @(posedge clk);
                rx_hold_req = 1'b0;
                queue_random(30);
            end
            else if (p == 3)
            begin
                queue_random(30);
                while (pending_items.size() > 15)
                    @(posedge clk);
                // pause the sender until every outstanding ciphertext has come back
                tx_pause = 1'b1;
                while (in_valid || cipher_queue.size() > 0)
                    @(posedge clk);
                tx_pause = 1'b0;
                queue_random(30);
            end
            else
            begin
                queue_random(60);
            end
            drain();
            calm = 1'b0;
        end

        $display("covered %0d checked ciphertexts, %0d store loads, 5 coefficient words",
                 cipher_count, load_count);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/aesbe_pkg.sv
rtl/aesbe_cell.sv
rtl/aesbe_mixcol.sv
rtl/aesbe_mem.sv
rtl/aes128_block_encrypt.sv
tb/aes128_block_encrypt_tb.sv
